@@ rtl/cflk_pkg.sv @@
// Shared types, constants and register codes of the candle flicker generator.
package cflk_pkg;

    // Default state store depth
    localparam int PIXEL_COUNT_DEFAULT = 1024;

    // Brightest level and the halving shift of green
    localparam logic [7:0] LEVEL_MAX   = 8'd255;
    localparam int         GREEN_SHIFT = 1;

    // Configuration register indexes
    localparam logic [2:0] REG_FLAME_AGILITY    = 3'd0;
    localparam logic [2:0] REG_WIND_BASELINE    = 3'd1;
    localparam logic [2:0] REG_WIND_VARIABILITY = 3'd2;
    localparam logic [2:0] REG_WIND_CALMNESS    = 3'd3;
    localparam logic [2:0] REG_PER_NODE         = 3'd4;
    localparam logic [2:0] REG_USE_PALETTE      = 3'd5;

    // Input word
    typedef struct packed {
        logic [9:0] pixel_index;
        logic       load;
        logic [7:0] red_gust_roll;
        logic [7:0] red_gust_level;
        logic [7:0] red_knock_roll;
        logic [7:0] red_knock_level;
        logic [7:0] green_gust_roll;
        logic [7:0] green_gust_level;
        logic [7:0] green_knock_roll;
        logic [7:0] green_knock_level;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [9:0] pixel_number;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } out_word_t;

    // Configuration write word
    typedef struct packed {
        logic [2:0] index;
        logic [7:0] value;
    } cfg_word_t;

    // Configuration register set
    typedef struct packed {
        logic [3:0] flame_agility;
        logic [7:0] wind_baseline;
        logic [7:0] wind_variability;
        logic [2:0] wind_calmness;
        logic       per_node;
        logic       use_palette;
    } cfg_regs_t;

    // One state entry: flames, smoothed levels and the shared wind
    typedef struct packed {
        logic [7:0] fr;
        logic [7:0] pr;
        logic [7:0] fg;
        logic [7:0] pg;
        logic [7:0] wind;
    } entry_t;

endpackage

@@ rtl/cflk_chan_if.sv @@
// Valid/ready channel carrying one word of a given type.
interface cflk_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/cflk_update.sv @@
// Per-frame flame update of one state entry and its colour word.
module cflk_update (
    input  cflk_pkg::cfg_regs_t cfg,
    input  cflk_pkg::in_word_t  item,
    input  logic                store_ok,
    input  cflk_pkg::entry_t    entry_cur,
    output cflk_pkg::entry_t    entry_new,
    output cflk_pkg::out_word_t word
);
    import cflk_pkg::*;

    typedef struct packed {
        logic [7:0] prime;
        logic [7:0] flame;
        logic [7:0] wind;
    } pass_t;

    // One colour pass: gust, wind decay, rise and knock-down, smoothing
    function automatic pass_t flame_pass(
        input cfg_regs_t  c,
        input logic [7:0] prime,
        input logic [7:0] flame,
        input logic [7:0] wind,
        input logic [7:0] gust_roll,
        input logic [7:0] gust_level,
        input logic [7:0] knock_roll,
        input logic [7:0] knock_level
    );
        pass_t      p;
        logic [7:0] w;
        logic [7:0] f;
        logic [8:0] up;
        logic [7:0] agl;
        agl = {4'd0, c.flame_agility};
        w = (gust_roll < c.wind_variability) ? gust_level : wind;
        if (w > c.wind_baseline)
            w = w - 8'd1;
        f = (flame != LEVEL_MAX) ? flame + 8'd1 : flame;
        if (knock_roll < (w >> c.wind_calmness))
            f = knock_level;
        up = {1'b0, prime} + {1'b0, agl};
        p.prime = prime;
        if (f > prime) begin
            if (up < {1'b0, LEVEL_MAX})
                p.prime = up[7:0];
        end
        else begin
            if (prime > agl)
                p.prime = prime - agl;
        end
        p.flame = f;
        p.wind  = w;
        return p;
    endfunction

    pass_t       red_p;
    pass_t       green_p;
    entry_t      upd;
    entry_t      seed;
    logic [15:0] seed_fg;
    logic [15:0] seed_pg;
    logic [7:0]  grey;

    // Run red then green, then clamp smoothed green
    always_comb
    begin
        red_p = flame_pass(cfg, entry_cur.pr, entry_cur.fr, entry_cur.wind,
                           item.red_gust_roll, item.red_gust_level,
                           item.red_knock_roll, item.red_knock_level);
        green_p = flame_pass(cfg, entry_cur.pg, entry_cur.fg, red_p.wind,
                             item.green_gust_roll, item.green_gust_level,
                             item.green_knock_roll, item.green_knock_level);
        upd.fr   = red_p.flame;
        upd.pr   = red_p.prime;
        upd.fg   = green_p.flame;
        upd.wind = green_p.wind;
        upd.pg   = (green_p.prime > red_p.prime) ? red_p.prime : green_p.prime;
        if (green_p.flame > red_p.flame)
            upd.pg = red_p.prime;
    end

    // Seed the entry from the random bytes
    assign seed_fg   = {8'd0, item.red_knock_roll} * {8'd0, item.red_gust_roll};
    assign seed_pg   = {8'd0, item.red_knock_level} * {8'd0, item.red_gust_level};
    assign seed.fr   = item.red_gust_roll;
    assign seed.pr   = item.red_gust_level;
    assign seed.fg   = seed_fg[15:8];
    assign seed.pg   = seed_pg[15:8];
    assign seed.wind = item.green_gust_roll;

    assign entry_new = item.load ? seed : upd;

    // Build the colour word; an out-of-range pixel shows black
    assign grey = LEVEL_MAX - entry_new.pr;

    always_comb
    begin
        word.pixel_number = item.pixel_index;
        word.out_red      = 8'd0;
        word.out_green    = 8'd0;
        word.out_blue     = 8'd0;
        if (store_ok) begin
            if (cfg.use_palette) begin
                word.out_red   = grey;
                word.out_green = grey;
                word.out_blue  = grey;
            end
            else begin
                word.out_red   = entry_new.pr;
                word.out_green = entry_new.pg >> GREEN_SHIFT;
            end
        end
    end

endmodule

@@ rtl/candle_flicker_generator_unit.sv @@
// Candle flicker generator: top level with state store, pipeline and configuration.
// Takes pixel words and passes each one's colour word through the input register and the
// output register to the output; while not stalled the rate is one word per clock, set by the
// state store having one read and one write port, with the entry written in the cycle it
// leaves for the output register and forwarded to a following word for the same pixel. A
// full output register that is not taken stalls the pipeline, and input ready drops only
// then. The store holds PIXEL_COUNT entries of 40 bits, is not cleared after reset and must
// be seeded with a load word before a pixel is updated. With per_node off every word works
// on entry 0; with it on, a pixel beyond the store gives a black word and changes nothing.
// Configuration writes are taken at any time but belong to idle periods.
module candle_flicker_generator_unit #(
    parameter int PIXEL_COUNT = cflk_pkg::PIXEL_COUNT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    cflk_chan_if.sink   pixel_in,
    cflk_chan_if.source pixel_out,
    cflk_chan_if.sink   cfg
);
    import cflk_pkg::*;

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    cfg_regs_t   cfg_reg;
    in_word_t    in_word;
    cfg_word_t   cfg_word;

    in_word_t    s1_item_reg;
    logic [AW-1:0] s1_addr_reg;
    logic        s1_ok_reg;
    logic        s1_valid_reg;

    entry_t      store_mem [PIXEL_COUNT];
    entry_t      rd_data_reg;
    logic [AW-1:0] rd_addr_next;

    entry_t      wr_data_reg;
    logic [AW-1:0] wr_addr_reg;
    logic        wr_valid_reg;

    out_word_t   out_word_reg;
    logic        out_valid_reg;

    logic [AW-1:0] in_addr;
    logic        in_ok;
    logic        in_take;
    logic        advance;
    logic        wr_en;
    entry_t      entry_cur;
    entry_t      entry_new;
    out_word_t   word_new;

    assign in_word  = pixel_in.data;
    assign cfg_word = cfg.data;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.flame_agility    <= 4'd2;
            cfg_reg.wind_baseline    <= 8'd30;
            cfg_reg.wind_variability <= 8'd5;
            cfg_reg.wind_calmness    <= 3'd2;
            cfg_reg.per_node         <= 1'b0;
            cfg_reg.use_palette      <= 1'b0;
        end
        else if (cfg.valid) begin
            unique case (cfg_word.index)
                REG_FLAME_AGILITY:    cfg_reg.flame_agility    <= cfg_word.value[3:0];
                REG_WIND_BASELINE:    cfg_reg.wind_baseline    <= cfg_word.value;
                REG_WIND_VARIABILITY: cfg_reg.wind_variability <= cfg_word.value;
                REG_WIND_CALMNESS:    cfg_reg.wind_calmness    <= cfg_word.value[2:0];
                REG_PER_NODE:         cfg_reg.per_node         <= cfg_word.value[0];
                REG_USE_PALETTE:      cfg_reg.use_palette      <= cfg_word.value[0];
                default:              ;
            endcase
        end
    end

    // Handshake: advance when the output register is free or being emptied
    assign advance        = s1_valid_reg && (!out_valid_reg || pixel_out.ready);
    assign pixel_in.ready = !s1_valid_reg || advance;
    assign in_take        = pixel_in.valid && pixel_in.ready;

    // Select the entry of an incoming word
    assign in_addr = cfg_reg.per_node ? AW'(in_word.pixel_index) : '0;
    assign in_ok   = !cfg_reg.per_node || (32'(in_word.pixel_index) < PIXEL_COUNT);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pixel_in.ready)
            s1_valid_reg <= pixel_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            s1_item_reg <= in_word;
            s1_addr_reg <= in_addr;
            s1_ok_reg   <= in_ok;
        end
    end

    // State store: read the entry of the word held next cycle, write on advance
    assign rd_addr_next = in_take ? in_addr : s1_addr_reg;
    assign wr_en        = advance && s1_ok_reg;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= store_mem[rd_addr_next];
        if (wr_en)
            store_mem[s1_addr_reg] <= entry_new;
    end

    // Remember the last write to forward it past the registered read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_valid_reg <= 1'b0;
        else
            wr_valid_reg <= wr_en;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            wr_addr_reg <= s1_addr_reg;
            wr_data_reg <= entry_new;
        end
    end

    assign entry_cur = (wr_valid_reg && (wr_addr_reg == s1_addr_reg)) ? wr_data_reg
                                                                      : rd_data_reg;

    // Update the entry and build the colour word
    cflk_update u_update (
        .cfg       (cfg_reg),
        .item      (s1_item_reg),
        .store_ok  (s1_ok_reg),
        .entry_cur (entry_cur),
        .entry_new (entry_new),
        .word      (word_new)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (pixel_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_word_reg <= word_new;
    end

    assign pixel_out.valid = out_valid_reg;
    assign pixel_out.data  = out_word_reg;

    // Checks
    a_take_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |-> (!s1_valid_reg || advance))
        else $error("word taken while the input register is held");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced word missing from output register");

    a_held_word_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("held word lost or changed");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (s1_valid_reg && s1_ok_reg))
        else $error("store written without a valid in-range word");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the candle flicker generator: predicted colours vs the pixel stream.
module tb_top;
    import cflk_pkg::*;

    localparam int DEPTH          = PIXEL_COUNT_DEFAULT;
    localparam int LATENCY_SLACK  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int POOL_SIZE      = 6;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_WORDS    = 210;

    // One colour lane during a flame pass: smoothed level, flame and the shared wind
    typedef struct packed {
        logic [7:0] prime;
        logic [7:0] flame;
        logic [7:0] wind;
    } flame_lane_t;

    // Colour predictor and store of colour words still owed by the block
    class flame_scoreboard;
        entry_t      flame_mem [DEPTH];
        cfg_regs_t   regs;
        out_word_t   colour_queue [$];
        int unsigned mismatches;

        function new();
            foreach (flame_mem[i])
                flame_mem[i] = '0;
            regs.flame_agility    = 4'd2;
            regs.wind_baseline    = 8'd30;
            regs.wind_variability = 8'd5;
            regs.wind_calmness    = 3'd2;
            regs.per_node         = 1'b0;
            regs.use_palette      = 1'b0;
            mismatches            = 0;
        endfunction

        task report(string msg);
            $display("[%0t] colour mismatch: %s", $time, msg);
            mismatches++;
        endtask

        function int pending();
            return colour_queue.size();
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                REG_FLAME_AGILITY:    regs.flame_agility    = val[3:0];
                REG_WIND_BASELINE:    regs.wind_baseline    = val;
                REG_WIND_VARIABILITY: regs.wind_variability = val;
                REG_WIND_CALMNESS:    regs.wind_calmness    = val[2:0];
                REG_PER_NODE:         regs.per_node         = val[0];
                REG_USE_PALETTE:      regs.use_palette      = val[0];
                default: ;
            endcase
        endfunction

        // Gust, wind decay, flame rise and knock, then one smoothing step
        function flame_lane_t advance_lane(flame_lane_t s, logic [7:0] gust_roll,
                                           logic [7:0] gust_level, logic [7:0] knock_roll,
                                           logic [7:0] knock_level);
            int unsigned step;
            step = regs.flame_agility;
            if (gust_roll < regs.wind_variability)
                s.wind = gust_level;
            if (s.wind > regs.wind_baseline)
                s.wind = s.wind - 8'd1;
            if (s.flame < LEVEL_MAX)
                s.flame = s.flame + 8'd1;
            if (knock_roll < (s.wind >> regs.wind_calmness))
                s.flame = knock_level;
            if (s.flame > s.prime)
            begin
                if (s.prime + step < 255)
                    s.prime = 8'(s.prime + step);
            end
            else if (s.prime > step)
            begin
                s.prime = 8'(s.prime - step);
            end
            return s;
        endfunction

        // Note an accepted pixel word: update the entry and queue its colour
        function void predict_colour(in_word_t w);
            entry_t      e;
            flame_lane_t lane;
            out_word_t   r;
            logic [15:0] prod;
            logic [7:0]  grey;
            int unsigned slot;
            r              = '0;
            r.pixel_number = w.pixel_index;
            slot           = 0;
            if (regs.per_node)
            begin
                if (w.pixel_index >= DEPTH)
                begin
                    colour_queue.push_back(r);
                    return;
                end
                slot = w.pixel_index;
            end
            e = flame_mem[slot];
            if (w.load)
            begin
                e.fr   = w.red_gust_roll;
                e.pr   = w.red_gust_level;
                prod   = {8'd0, w.red_knock_roll} * {8'd0, e.fr};
                e.fg   = prod[15:8];
                prod   = {8'd0, w.red_knock_level} * {8'd0, e.pr};
                e.pg   = prod[15:8];
                e.wind = w.green_gust_roll;
            end
            else
            begin
                lane = '{prime: e.pr, flame: e.fr, wind: e.wind};
                lane = advance_lane(lane, w.red_gust_roll, w.red_gust_level,
                                    w.red_knock_roll, w.red_knock_level);
                e.pr       = lane.prime;
                e.fr       = lane.flame;
                lane.prime = e.pg;
                lane.flame = e.fg;
                lane = advance_lane(lane, w.green_gust_roll, w.green_gust_level,
                                    w.green_knock_roll, w.green_knock_level);
                e.pg   = lane.prime;
                e.fg   = lane.flame;
                e.wind = lane.wind;
                // clamp smoothed green to smoothed red
                if (e.pg > e.pr)
                    e.pg = e.pr;
                if (e.fg > e.fr)
                    e.pg = e.pr;
            end
            flame_mem[slot] = e;
            if (regs.use_palette)
            begin
                grey        = LEVEL_MAX - e.pr;
                r.out_red   = grey;
                r.out_green = grey;
                r.out_blue  = grey;
            end
            else
            begin
                r.out_red   = e.pr;
                r.out_green = e.pg >> GREEN_SHIFT;
                r.out_blue  = '0;
            end
            colour_queue.push_back(r);
        endfunction

        // Compare a colour word with the oldest one owed, field by field
        task check_result(out_word_t got);
            out_word_t want;
            if (colour_queue.size() == 0)
            begin
                report($sformatf("unexpected word for pixel %0d", got.pixel_number));
                return;
            end
            want = colour_queue.pop_front();
            if (got.pixel_number != want.pixel_number)
                report($sformatf("pixel_number %0d, want %0d",
                                 got.pixel_number, want.pixel_number));
            if (got.out_red != want.out_red)
                report($sformatf("pixel %0d out_red %0d, want %0d",
                                 want.pixel_number, got.out_red, want.out_red));
            if (got.out_green != want.out_green)
                report($sformatf("pixel %0d out_green %0d, want %0d",
                                 want.pixel_number, got.out_green, want.out_green));
            if (got.out_blue != want.out_blue)
                report($sformatf("pixel %0d out_blue %0d, want %0d",
                                 want.pixel_number, got.out_blue, want.out_blue));
        endtask
    endclass

    logic clk;
    logic rst_n;

    cflk_chan_if #(.T(in_word_t))  pixel_in_if ();
    cflk_chan_if #(.T(out_word_t)) pixel_out_if ();
    cflk_chan_if #(.T(cfg_word_t)) cfg_if ();

    candle_flicker_generator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pixel_in_if),
        .pixel_out (pixel_out_if),
        .cfg       (cfg_if)
    );

    flame_scoreboard sb;
    bit              hold_request;
    bit              cur_per_node;
    logic [9:0]      live_pix [POOL_SIZE];
    int              idle_cycles;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watch handshakes: note inputs and register writes, check colour words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_in_if.valid && pixel_in_if.ready)
                sb.predict_colour(pixel_in_if.data);
            if (cfg_if.valid && cfg_if.ready)
                sb.set_reg(cfg_if.data.index, cfg_if.data.value);
            if (pixel_out_if.valid && pixel_out_if.ready)
                sb.check_result(pixel_out_if.data);
        end
    end

    // Watchdog: end the run after a long stretch with no word moving
    always @(posedge clk)
    begin
        if ((pixel_in_if.valid && pixel_in_if.ready) || (cfg_if.valid && cfg_if.ready)
            || (pixel_out_if.valid && pixel_out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("candle_flicker_generator_unit test failed");
            $finish;
        end
    end

    // Receiver: stall in segments of its own pattern; hold off long on request
    initial
    begin : receiver
        int mode;
        int span;
        int tick;
        pixel_out_if.ready = 1'b0;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 80);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                if (hold_request)
                begin
                    hold_request = 1'b0;
                    pixel_out_if.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end
                case (mode)
                    0:       pixel_out_if.ready <= 1'b1;
                    1:       pixel_out_if.ready <= 1'($urandom_range(0, 1));
                    default: pixel_out_if.ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    function automatic in_word_t make_word(int pix, bit ld, logic [7:0] b0, logic [7:0] b1,
                                           logic [7:0] b2, logic [7:0] b3, logic [7:0] b4,
                                           logic [7:0] b5, logic [7:0] b6, logic [7:0] b7);
        in_word_t w;
        w.pixel_index       = 10'(pix);
        w.load              = ld;
        w.red_gust_roll     = b0;
        w.red_gust_level    = b1;
        w.red_knock_roll    = b2;
        w.red_knock_level   = b3;
        w.green_gust_roll   = b4;
        w.green_gust_level  = b5;
        w.green_knock_roll  = b6;
        w.green_knock_level = b7;
        return w;
    endfunction

    // Rolls lean towards small values so that gusts and knocks happen often
    function automatic logic [7:0] roll_byte();
        if ($urandom_range(0, 2) == 0)
            return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic in_word_t random_word();
        return make_word($urandom_range(0, DEPTH - 1), 1'b0,
                         roll_byte(), 8'($urandom_range(0, 255)),
                         roll_byte(), 8'($urandom_range(0, 255)),
                         roll_byte(), 8'($urandom_range(0, 255)),
                         roll_byte(), 8'($urandom_range(0, 255)));
    endfunction

    // Next stimulus word: mostly updates of seeded entries, some fresh seeds
    function automatic in_word_t next_word();
        in_word_t w;
        int       slot;
        w      = random_word();
        w.load = ($urandom_range(0, 9) == 0);
        if (cur_per_node)
        begin
            slot = $urandom_range(0, POOL_SIZE - 1);
            if (w.load)
                live_pix[slot] = w.pixel_index;
            else
                w.pixel_index = live_pix[slot];
        end
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        @(negedge clk);
        pixel_in_if.valid <= 1'b1;
        pixel_in_if.data  <= w;
        @(posedge clk);
        while (!pixel_in_if.ready)
            @(posedge clk);
    endtask

    task automatic pause_input(input int n);
        @(negedge clk);
        pixel_in_if.valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Drop valid and hold until every owed colour word has come out
    task automatic drain();
        @(negedge clk);
        pixel_in_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY_SLACK) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, value: val};
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic apply_settings(input cfg_regs_t s);
        write_reg(REG_FLAME_AGILITY,    8'(s.flame_agility));
        write_reg(REG_WIND_BASELINE,    s.wind_baseline);
        write_reg(REG_WIND_VARIABILITY, s.wind_variability);
        write_reg(REG_WIND_CALMNESS,    8'(s.wind_calmness));
        write_reg(REG_PER_NODE,         8'(s.per_node));
        write_reg(REG_USE_PALETTE,      8'(s.use_palette));
        cur_per_node = s.per_node;
    endtask

    function automatic cfg_regs_t phase_setting(int ph);
        cfg_regs_t s;
        case (ph)
            0: s = '{flame_agility: 4'd2,  wind_baseline: 8'd30,  wind_variability: 8'd5,
                     wind_calmness: 3'd2, per_node: 1'b0, use_palette: 1'b0};
            1: s = '{flame_agility: 4'd0,  wind_baseline: 8'd0,   wind_variability: 8'd0,
                     wind_calmness: 3'd0, per_node: 1'b1, use_palette: 1'b0};
            2: s = '{flame_agility: 4'd15, wind_baseline: 8'd255, wind_variability: 8'd255,
                     wind_calmness: 3'd7, per_node: 1'b1, use_palette: 1'b1};
            3: s = '{flame_agility: 4'd1,  wind_baseline: 8'd128, wind_variability: 8'd40,
                     wind_calmness: 3'd3, per_node: 1'b0, use_palette: 1'b1};
            4: s = '{flame_agility: 4'd10, wind_baseline: 8'd30,  wind_variability: 8'd5,
                     wind_calmness: 3'd2, per_node: 1'b1, use_palette: 1'b0};
            default:
                s = '{flame_agility: 4'($urandom_range(0, 15)),
                      wind_baseline: 8'($urandom_range(0, 255)),
                      wind_variability: 8'($urandom_range(0, 255)),
                      wind_calmness: 3'($urandom_range(0, 7)),
                      per_node: 1'b1, use_palette: 1'($urandom_range(0, 1))};
        endcase
        return s;
    endfunction

    // Seed the pixel pool, both ends of the index range among them
    task automatic seed_pool();
        in_word_t w;
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            w      = random_word();
            w.load = 1'b1;
            if (k == 0)
                w.pixel_index = '0;
            else if (k == 1)
                w.pixel_index = 10'(DEPTH - 1);
            live_pix[k] = w.pixel_index;
            send_word(w);
        end
    endtask

    // Random words in bursts of random length with random gaps
    task automatic run_random(input int n);
        int burst_left;
        int gap;
        burst_left = 0;
        repeat (n)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 30);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                    pause_input(gap);
            end
            send_word(next_word());
            burst_left--;
        end
    endtask

    // Keep offering words while the receiver holds off, so the block backs up
    task automatic squeeze_input();
        hold_request = 1'b1;
        repeat (40) send_word(next_word());
    endtask

    // Directed words under reset settings: extremes, saturation, clamp, gust edge
    task automatic run_directed();
        send_word(make_word(0,    1, 0,   0,   0,   0,   0,   0,   0,   0));
        send_word(make_word(1,    0, 255, 255, 255, 255, 255, 255, 255, 255));
        send_word(make_word(2,    0, 0,   255, 0,   0,   0,   0,   255, 255));
        send_word(make_word(1023, 1, 255, 255, 255, 255, 255, 255, 255, 255));
        send_word(make_word(1023, 0, 255, 255, 255, 255, 255, 255, 255, 255));
        send_word(make_word(512,  1, 10,  250, 128, 255, 200, 0,   0,   0));
        repeat (3)
            send_word(make_word(512, 0, 255, 0, 0, 255, 255, 0, 255, 0));
        send_word(make_word(341,  0, 255, 0,   0,   0,   255, 0,   0,   255));
        send_word(make_word(682,  0, 255, 0,   255, 0,   255, 0,   255, 0));
        send_word(make_word(0,    0, 4,   0,   255, 0,   5,   17,  255, 0));
        send_word(make_word(341,  1, 0,   255, 255, 0,   0,   0,   0,   0));
        send_word(make_word(682,  0, 255, 255, 255, 255, 255, 255, 255, 255));
        send_word(make_word(85,   0, 0,   170, 0,   85,  0,   170, 0,   85));
        send_word(make_word(938,  0, 255, 85,  255, 170, 255, 85,  255, 170));
    endtask

    // Main sequence
    initial
    begin
        sb                 = new();
        rst_n              = 1'b0;
        hold_request       = 1'b0;
        cur_per_node       = 1'b0;
        idle_cycles        = 0;
        pixel_in_if.valid  = 1'b0;
        pixel_in_if.data   = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        foreach (live_pix[i])
            live_pix[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            drain();
            apply_settings(phase_setting(ph));
            if (cur_per_node)
                seed_pool();
            if (ph == 1)
                squeeze_input();
            if (ph == 3)
            begin
                run_random(PHASE_WORDS / 2);
                drain();
                run_random(PHASE_WORDS / 2);
            end
            else
            begin
                run_random(PHASE_WORDS);
            end
        end
        drain();

        if (sb.mismatches == 0)
            $display("candle_flicker_generator_unit test passed");
        else
            $display("candle_flicker_generator_unit test failed");
        $finish;
    end
endmodule
